/* rtl/core/pctd_pkg.sv */
// Package for the trial-division prime counter: request and result types,
// the internal modulo-unit handshake structs and fixed widths. No dependencies.
package pctd_pkg;

    localparam int VAL_W = 31;
    localparam int DIV_W = 16;
    localparam int SQ_W  = 32;
    localparam int CNT_W = 11;
    localparam int STEP_W = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
    localparam logic [DIV_W-1:0] FIRST_DIV = 16'd3;
    localparam logic [SQ_W-1:0]  FIRST_SQ  = 32'd9;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_t;

    typedef struct packed {
        logic                is_prime;
        logic [CNT_W-1:0]    prime_count;
        logic                end_of_array;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } mod_rsp_t;

    typedef struct packed {
        logic valid;
        logic is_prime;
        logic last;
    } res_t;

endpackage

/* rtl/core/prime_count_trial_division.sv */
// Flow: negative values, values below 4 and even values go from ST_IDLE straight to ST_OUT
// and enter the output register once it is free; odd values try odd divisors d = 3, 5, ...
// in the 31-step modulo unit (worst case 2^31 - 1 with 23169 divisors).
// Throughput: one request at a time; the next is taken only once the previous result has
// entered the output register. Reset (aresetn low, synchronous) clears the count and valids.
//
// Top level of the trial-division prime counter. Depends on pctd_pkg, pctd_ctrl
// and pctd_mod.
module prime_count_trial_division #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pctd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pctd_pkg::out_t m_data
);
    import pctd_pkg::*;

    // The running count saturates at the array length in use, or at the
    // largest value the count field can hold if that is smaller.
    localparam logic [CNT_W-1:0] CountCap =
        (MAX_ITEMS < 2047) ? CNT_W'(MAX_ITEMS) : CNT_MAX;

    res_t     res;
    mod_req_t mod_req;
    mod_rsp_t mod_rsp;

    logic             out_free;
    logic             load;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;

    // The sequencer screens the request and steps through odd divisors,
    // handing each trial division to the modulo unit.
    pctd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .res      (res),
        .mod_req  (mod_req),
        .mod_rsp  (mod_rsp)
    );

    pctd_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    // The output register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign load     = res.valid && out_free;

    always_comb begin
        if (res.is_prime && (count_reg < CountCap)) begin
            count_inc = count_reg + CNT_W'(1);
        end else begin
            count_inc = count_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        count_next   = count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next             = 1'b1;
            m_data_next.is_prime     = res.is_prime;
            m_data_next.prime_count  = count_inc;
            m_data_next.end_of_array = res.last;
            // A new array starts counting from zero after its last element.
            count_next = res.last ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountCap) else $error("count above cap");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending result overwritten");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !s_ready) else $error("ready while result pending");

endmodule

/* rtl/core/pctd_mod.sv */
// Iterative remainder unit: restoring shift-subtract, one dividend bit per cycle.
// Depends on pctd_pkg.
module pctd_mod (
    input  logic              aclk,
    input  logic              aresetn,
    input  pctd_pkg::mod_req_t req,
    output pctd_pkg::mod_rsp_t rsp
);
    import pctd_pkg::*;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  dvd_reg, dvd_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[VAL_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            // The remainder stays below the divisor, so the low bits hold it.
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[DIV_W-1:0];
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            dvd_next = {dvd_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            cnt_next  = STEP_W'(VAL_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("modulo start while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && !busy_reg)) else $error("done without work");
    a_div_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && $past(busy_reg)) |-> $stable(div_reg)) else $error("divisor changed");

endmodule

/* rtl/core/pctd_ctrl.sv */
// Sequencer for the primality test: screens trivial values, steps odd divisors
// and tracks the divisor square incrementally. Depends on pctd_pkg.
module pctd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pctd_pkg::in_t      s_data,
    input  logic               out_free,
    output pctd_pkg::res_t     res,
    output pctd_pkg::mod_req_t mod_req,
    input  pctd_pkg::mod_rsp_t mod_rsp
);
    import pctd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_OUT} state_t;

    state_t           state_reg, state_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             last_reg, last_next;
    logic             prime_reg, prime_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic             start_reg, start_next;
    logic [VAL_W-1:0] in_mag;

    assign in_mag = s_data.value[VAL_W-1:0];

    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        prime_next = prime_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        start_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next  = in_mag;
                    last_next = s_data.last;
                    d_next    = FIRST_DIV;
                    sq_next   = FIRST_SQ;
                    if (s_data.value[31] || (in_mag[VAL_W-1:1] == '0)) begin
                        prime_next = 1'b0;
                        state_next = ST_OUT;
                    end else if (in_mag[VAL_W-1:2] == '0) begin
                        prime_next = 1'b1;
                        state_next = ST_OUT;
                    end else if (!in_mag[0]) begin
                        prime_next = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (sq_reg > {1'b0, val_reg}) begin
                    prime_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    start_next = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mod_rsp.done) begin
                    if (mod_rsp.zero) begin
                        prime_next = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        d_next     = d_reg + DIV_W'(2);
                        sq_next    = sq_reg + {{(SQ_W-DIV_W-2){1'b0}}, d_reg, 2'b00}
                                     + SQ_W'(4);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
        val_reg   <= val_next;
        last_reg  <= last_next;
        prime_reg <= prime_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign res.valid        = (state_reg == ST_OUT);
    assign res.is_prime     = prime_reg;
    assign res.last         = last_reg;
    assign mod_req.start    = start_reg;
    assign mod_req.dividend = val_reg;
    assign mod_req.divisor  = d_reg;

    a_odd_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> d_reg[0]) else $error("even divisor");
    a_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |->
        (sq_reg == ({{(SQ_W-DIV_W){1'b0}}, d_reg} * {{(SQ_W-DIV_W){1'b0}}, d_reg})))
        else $error("divisor square out of step");
    a_start_once: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (state_reg == ST_DIV)) else $error("stray modulo start");

endmodule

/* tb/prime_count_trial_division_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for prime_count_trial_division: a directed table, then random
// arrays under several idle patterns, a long output hold-off and a run of primes.
// Depends on pctd_pkg and the prime_count_trial_division RTL only.
module prime_count_trial_division_tb;
    import pctd_pkg::*;

    localparam int MAX_ITEMS        = 1024;
    // The running count stops at MAX_ITEMS, or at the 11-bit ceiling if that is lower.
    localparam int COUNT_CAP        = (MAX_ITEMS < 2047) ? MAX_ITEMS : 2047;
    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 4;
    localparam int RANDOM_PER_PHASE = 15;
    localparam int PRESSURE_ITEMS   = 12;
    localparam int HOLD_CYCLES      = 300;
    localparam int PRIME_RUN_ITEMS  = 10;
    localparam int DRAIN_CYCLES     = 100;
    // The watchdog limit lies above the quiet stretch of the slowest request (2^31 - 1,
    // a prime), so that request is not taken for a hung run.
    localparam int WATCHDOG_LIMIT   = 3_000_000;

    typedef enum logic [1:0] {
        PH_DIRECTED,
        PH_RANDOM,
        PH_PRESSURE,
        PH_PRIME_RUN
    } phase_t;

    // One row of the directed table. When typed is set, the row carries its expected
    // result; otherwise the prime predictor below supplies it.
    typedef struct {
        logic [31:0] value;
        bit          last;
        bit          typed;
        bit          exp_prime;
        int          exp_count;
        bit          exp_end;
    } directed_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    phase_t phase         = PH_DIRECTED;
    int     src_idle_pct  = 0;
    int     snk_stall_pct = 0;
    int     error_count   = 0;
    int     quiet_cycles  = 0;

    // Predictor state: primes counted so far in the array that is currently open.
    logic [CNT_W-1:0] array_prime_count = '0;
    // Results owed by the block, oldest first.
    out_t pending_verdicts [$];

    // Extremes, every special case and both values of last. The count column is
    // read straight off the sequence: only 2, 3 and 2^31 - 1 are primes up to row 10.
    directed_row_t directed_rows [21] = '{
        '{32'd0,          1'b0, 1'b1, 1'b0, 0, 1'b0},
        '{32'd1,          1'b0, 1'b1, 1'b0, 0, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 1'b1, 1'b0, 0, 1'b0},
        '{32'h8000_0000,  1'b0, 1'b1, 1'b0, 0, 1'b0},
        '{32'd2,          1'b0, 1'b1, 1'b1, 1, 1'b0},
        '{32'd3,          1'b0, 1'b1, 1'b1, 2, 1'b0},
        '{32'd4,          1'b0, 1'b1, 1'b0, 2, 1'b0},
        '{32'd9,          1'b0, 1'b1, 1'b0, 2, 1'b0},
        '{32'd25,         1'b0, 1'b1, 1'b0, 2, 1'b0},
        '{32'h7FFF_FFFF,  1'b1, 1'b1, 1'b1, 3, 1'b1},
        '{32'h7FFF_FFFE,  1'b0, 1'b1, 1'b0, 0, 1'b0},
        '{32'd1,          1'b1, 1'b1, 1'b0, 0, 1'b1},
        '{32'd2,          1'b1, 1'b1, 1'b1, 1, 1'b1},
        '{32'd5,          1'b0, 1'b0, 1'b0, 0, 1'b0},
        '{32'd49,         1'b0, 1'b0, 1'b0, 0, 1'b0},
        '{32'd169,        1'b0, 1'b0, 1'b0, 0, 1'b0},
        '{32'd65521,      1'b0, 1'b0, 1'b0, 0, 1'b0},
        '{32'd65535,      1'b0, 1'b0, 1'b0, 0, 1'b0},
        '{32'h7FFF_FFFD,  1'b0, 1'b0, 1'b0, 0, 1'b0},
        '{32'h8000_0001,  1'b0, 1'b0, 1'b0, 0, 1'b0},
        '{32'd97,         1'b1, 1'b0, 1'b0, 0, 1'b0}
    };

    // Idle patterns of the four random phases: none, sender only, receiver only, both.
    int src_idle_by_phase [4] = '{0, 62, 0, 21};
    int snk_idle_by_phase [4] = '{0, 0, 62, 21};

    // Small primes for the run in which every request adds to the count.
    int small_primes [6] = '{2, 3, 5, 7, 11, 13};

    prime_count_trial_division #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Trial division with the exact bound d*d <= v. Negative values, zero and one are
    // not prime; even values above 2 fail at once, so only odd divisors are tried.
    function automatic bit trial_division_prime(logic [31:0] raw);
        longint unsigned v;
        longint unsigned d;
        if (raw[31]) begin
            return 1'b0;
        end
        v = longint'(raw);
        if (v < 2) begin
            return 1'b0;
        end
        if (v < 4) begin
            return 1'b1;
        end
        if (v[0] == 1'b0) begin
            return 1'b0;
        end
        for (d = 3; d * d <= v; d += 2) begin
            if (v % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Works out the result of one request and advances the running count. The count
    // saturates rather than wraps, and it clears once the last element has gone by.
    function automatic out_t count_primes(in_t req);
        out_t res;
        bit   prime;
        prime            = trial_division_prime(req.value);
        res.is_prime     = prime;
        res.prime_count  = array_prime_count;
        res.end_of_array = req.last;
        if (prime && array_prime_count < COUNT_CAP) begin
            res.prime_count = array_prime_count + 1'b1;
        end
        array_prime_count = req.last ? '0 : res.prime_count;
        return res;
    endfunction

    // Random element. Most are small so that the trial division stays short; large
    // positive values are made even or a multiple of three, which the block rejects
    // after at most one division, and negatives cost nothing at all.
    function automatic logic [31:0] pick_value();
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(99);
        if (sel < 55) begin
            v = $urandom_range(2000);
        end else if (sel < 65) begin
            v = $urandom_range(70000);
        end else if (sel < 80) begin
            v = $urandom_range(32'h2AAA_AAAA) * 3;
        end else if (sel < 90) begin
            v = $urandom;
            v[0] = 1'b0;
        end else begin
            v = $urandom | 32'h8000_0000;
        end
        return v;
    endfunction

    // Offers one request, idling first at the current sender rate, and holds it until
    // the block takes it. The expectation is recorded at the edge of acceptance.
    task automatic offer_request(logic [31:0] value, bit last, bit typed,
                                 out_t typed_result);
        in_t  req;
        out_t predicted;
        req.value = value;
        req.last  = last;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        // The predictor always runs so its count tracks the block, even when the
        // table supplies the expected result for this row.
        predicted = count_primes(req);
        pending_verdicts.push_back(typed ? typed_result : predicted);
    endtask

    // Arrays of one to eight elements with random content; now and then an early last
    // mark cuts an array short, and the item limit can end the final array without one.
    task automatic run_random_arrays(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len && sent < n_items; k++) begin
                offer_request(pick_value(), (k == len - 1) || ($urandom_range(99) < 4),
                              1'b0, '0);
                sent++;
            end
        end
    endtask

    // Result side: checks every accepted result against the oldest expectation and
    // drives m_ready. In the pressure phase it holds m_ready low for a long stretch,
    // so the block fills up and must drop s_ready while requests keep coming.
    initial begin : result_side
        int   hold_left;
        bit   pressure_done;
        out_t want;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing expected: %p", m_data));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_data.is_prime !== want.is_prime) begin
                        flag_mismatch($sformatf("is_prime got %0b want %0b",
                                                m_data.is_prime, want.is_prime));
                    end
                    if (m_data.prime_count !== want.prime_count) begin
                        flag_mismatch($sformatf("prime_count got %0d want %0d",
                                                m_data.prime_count, want.prime_count));
                    end
                    if (m_data.end_of_array !== want.end_of_array) begin
                        flag_mismatch($sformatf("end_of_array got %0b want %0b",
                                                m_data.end_of_array, want.end_of_array));
                    end
                end
            end
            if (phase == PH_PRESSURE && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= aresetn && ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // A hang shows up as a long run of cycles in which neither side moves a request.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL prime_count_trial_division");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : request_side
        out_t typed_result;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, no idling on either side.
        foreach (directed_rows[i]) begin
            typed_result.is_prime     = directed_rows[i].exp_prime;
            typed_result.prime_count  = directed_rows[i].exp_count[CNT_W-1:0];
            typed_result.end_of_array = directed_rows[i].exp_end;
            offer_request(directed_rows[i].value, directed_rows[i].last,
                          directed_rows[i].typed, typed_result);
        end

        // Random arrays under each idle pattern in turn.
        phase = PH_RANDOM;
        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = src_idle_by_phase[p];
            snk_stall_pct = snk_idle_by_phase[p];
            run_random_arrays(RANDOM_PER_PHASE);
        end

        // Back-to-back cheap requests while the result side holds off.
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        phase         = PH_PRESSURE;
        for (int k = 0; k < PRESSURE_ITEMS; k++) begin
            offer_request($urandom_range(40), $urandom_range(99) < 25, 1'b0, '0);
        end

        // A run of small primes in one array, so the count climbs on every request
        // and clears after the last element; then a lone prime in an array of its own.
        phase         = PH_PRIME_RUN;
        snk_stall_pct = 21;
        for (int k = 0; k < PRIME_RUN_ITEMS; k++) begin
            offer_request(32'(small_primes[$urandom_range(5)]),
                          k == PRIME_RUN_ITEMS - 1, 1'b0, '0);
        end
        offer_request(32'd3, 1'b1, 1'b0, '0);
        s_valid <= 1'b0;

        while (pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("PASS prime_count_trial_division");
        end else begin
            $display("FAIL prime_count_trial_division");
        end
        $finish;
    end

endmodule
